[hdl/tmp_pkg.sv]
package tmp_pkg;

   localparam int DATA_W  = 32;
   localparam int LIMIT_N = 4;
   localparam int CSR_W   = 31;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      PH_STOP      = 3'd0,
      PH_INITDECEL = 3'd1,
      PH_ACCEL     = 3'd2,
      PH_CRUISE    = 3'd3,
      PH_DECEL     = 3'd4
   } phase_type;

   localparam logic CSR_MAX_SPEED  = 1'b0;
   localparam logic CSR_ACCEL_STEP = 1'b1;

   localparam logic [CSR_W-1:0] MAX_SPEED_RESET  = 31'd16777216;
   localparam logic [CSR_W-1:0] ACCEL_STEP_RESET = 31'd16777;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [2:0]               start_phase;
      logic signed [DATA_W-1:0] start_speed;
      logic                     direction;
      logic                     continuous;
      logic signed [DATA_W-1:0] limit_decel_to_accel;
      logic signed [DATA_W-1:0] limit_accel_to_cruise;
      logic signed [DATA_W-1:0] limit_cruise_to_decel;
      logic signed [DATA_W-1:0] limit_decel_to_stop;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] speed_out;
      logic signed [DATA_W-1:0] step_position;
      logic [2:0]               phase_out;
   } rsp_type;

endpackage

[hdl/trapezoidal_motion_profile.sv]
// Trapezoidal velocity profile generator. Each request is a tick, a move
// start or a stop, and produces exactly one response with the speed (Q8.24
// steps per tick), the rounded step position and the phase after it. A
// request is taken in every cycle the response register is free or being
// drained, and its response appears on the next cycle: one request per
// clock while rsp_ready keeps the response register draining. Write
// max_speed and accel_step only while no request is in flight.
module trapezoidal_motion_profile #(
   parameter int FRAC_BITS = 24,
   parameter int POS_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tmp_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tmp_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [tmp_pkg::CSR_W-1:0]     csr_wdata
);
   import tmp_pkg::*;

   logic [CSR_W-1:0] max_speed_ff, max_speed_in;
   logic [CSR_W-1:0] accel_step_ff, accel_step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          result;
   logic             req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   tmp_core #(
      .FRAC_BITS (FRAC_BITS),
      .POS_BITS  (POS_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .req        (req_data),
      .max_speed  (max_speed_ff),
      .accel_step (accel_step_ff),
      .result     (result)
   );

   always_comb begin
      max_speed_in  = max_speed_ff;
      accel_step_in = accel_step_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_SPEED:  max_speed_in  = csr_wdata;
            CSR_ACCEL_STEP: accel_step_in = csr_wdata;
         endcase
      end
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= MAX_SPEED_RESET;
         accel_step_ff <= ACCEL_STEP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         max_speed_ff  <= max_speed_in;
         accel_step_ff <= accel_step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_ff <= result;
   end

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted request produced no response");

   a_stop_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.cmd == CMD_STOP) |=>
         (rsp_data.phase_out == PH_STOP && rsp_data.speed_out == '0))
      else $error("stop request did not clear speed and phase");

   a_tick_stop_speed: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.cmd == CMD_TICK) |=>
         (rsp_data.phase_out != PH_STOP || rsp_data.speed_out == '0))
      else $error("tick left nonzero speed in stop phase");

endmodule

[hdl/tmp_kin.sv]
module tmp_kin #(
   parameter int FRAC_BITS = 24,
   parameter int POS_BITS  = 32
) (
   input  logic signed [tmp_pkg::DATA_W-1:0]       speed,
   input  logic signed [tmp_pkg::DATA_W-1:0]       accel,
   input  logic signed [POS_BITS+FRAC_BITS-1:0]    acc,
   input  logic                                    ccw,
   input  logic [tmp_pkg::CSR_W-1:0]               max_speed,
   output logic signed [tmp_pkg::DATA_W-1:0]       speed_next,
   output logic signed [POS_BITS+FRAC_BITS-1:0]    acc_next,
   output logic signed [POS_BITS-1:0]              pos_next
);
   import tmp_pkg::*;

   localparam int ACC_W = POS_BITS + FRAC_BITS;
   localparam int SUM_W = ((ACC_W > DATA_W) ? ACC_W : DATA_W) + 1;
   localparam int V_W   = ACC_W + 1;
   localparam int Q_W   = POS_BITS + 1;

   logic signed [DATA_W:0]   spd_sum;
   logic signed [DATA_W-1:0] spd_sat;
   logic signed [DATA_W-1:0] vmax;
   logic signed [DATA_W-1:0] vmax_neg;
   logic signed [SUM_W-1:0]  acc_sum;
   logic [SUM_W-ACC_W:0]     acc_top;
   logic signed [V_W-1:0]    v;
   logic signed [Q_W-1:0]    q;
   logic signed [Q_W-1:0]    r;
   logic                     frac_nz;

   // speed = sat32(speed + accel), then clamp in the travel direction
   always_comb begin
      spd_sum  = (DATA_W+1)'(speed) + (DATA_W+1)'(accel);
      if (spd_sum[DATA_W] != spd_sum[DATA_W-1])
         spd_sat = spd_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      else
         spd_sat = spd_sum[DATA_W-1:0];
      vmax     = $signed({1'b0, max_speed});
      vmax_neg = -vmax;
      speed_next = spd_sat;
      if (!ccw) begin
         if (spd_sat >= vmax) speed_next = vmax;
      end else begin
         if (spd_sat <= vmax_neg) speed_next = vmax_neg;
      end
   end

   // position accumulator with saturation at ACC_W signed bits
   always_comb begin
      acc_sum = SUM_W'(acc) + SUM_W'(speed_next);
      acc_top = acc_sum[SUM_W-1:ACC_W-1];
      if ((&acc_top) || !(|acc_top))
         acc_next = acc_sum[ACC_W-1:0];
      else if (acc_sum[SUM_W-1])
         acc_next = {1'b1, {(ACC_W-1){1'b0}}};
      else
         acc_next = {1'b0, {(ACC_W-1){1'b1}}};
   end

   // add one half, truncate toward zero, saturate to POS_BITS
   always_comb begin
      v       = V_W'(acc_next) + V_W'({1'b1, {(FRAC_BITS-1){1'b0}}});
      q       = v[V_W-1:FRAC_BITS];
      frac_nz = |v[FRAC_BITS-1:0];
      r       = q + Q_W'(v[V_W-1] & frac_nz);
      if (r[Q_W-1] != r[Q_W-2])
         pos_next = r[Q_W-1] ? {1'b1, {(POS_BITS-1){1'b0}}} : {1'b0, {(POS_BITS-1){1'b1}}};
      else
         pos_next = r[POS_BITS-1:0];
   end

endmodule

[hdl/tmp_core.sv]
module tmp_core #(
   parameter int FRAC_BITS = 24,
   parameter int POS_BITS  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  tmp_pkg::req_type             req,
   input  logic [tmp_pkg::CSR_W-1:0]    max_speed,
   input  logic [tmp_pkg::CSR_W-1:0]    accel_step,
   output tmp_pkg::rsp_type             result
);
   import tmp_pkg::*;

   localparam int ACC_W = POS_BITS + FRAC_BITS;

   phase_type                phase_ff, phase_in;
   logic signed [DATA_W-1:0] speed_ff, speed_in;
   logic signed [DATA_W-1:0] accel_ff, accel_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [POS_BITS-1:0] pos_ff, pos_in;
   logic                     dir_ff, dir_in;
   logic                     cont_ff, cont_in;
   logic signed [DATA_W-1:0] limit_ff [LIMIT_N];
   logic signed [DATA_W-1:0] limit_in [LIMIT_N];

   logic signed [DATA_W-1:0] spd_tick;
   logic signed [ACC_W-1:0]  acc_tick;
   logic signed [POS_BITS-1:0] pos_tick;
   logic signed [DATA_W-1:0] pos_ext;
   logic signed [DATA_W-1:0] a_pos, a_neg;
   logic                     cw;

   tmp_kin #(
      .FRAC_BITS (FRAC_BITS),
      .POS_BITS  (POS_BITS)
   ) u_kin (
      .speed      (speed_ff),
      .accel      (accel_ff),
      .acc        (acc_ff),
      .ccw        (dir_ff),
      .max_speed  (max_speed),
      .speed_next (spd_tick),
      .acc_next   (acc_tick),
      .pos_next   (pos_tick)
   );

   always_comb begin
      cw       = !dir_ff;
      pos_ext  = DATA_W'(pos_tick);
      a_pos    = $signed({1'b0, accel_step});
      a_neg    = -a_pos;
      phase_in = phase_ff;
      speed_in = speed_ff;
      accel_in = accel_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      dir_in   = dir_ff;
      cont_in  = cont_ff;
      for (int i = 0; i < LIMIT_N; i++) limit_in[i] = limit_ff[i];

      unique case (req.cmd)
         CMD_TICK: begin
            speed_in = spd_tick;
            acc_in   = acc_tick;
            pos_in   = pos_tick;
            unique case (phase_ff)
               PH_INITDECEL: begin
                  accel_in = cw ? a_pos : a_neg;
                  if (pos_ext >= limit_ff[0]) phase_in = PH_ACCEL;
               end
               PH_ACCEL: begin
                  accel_in = cw ? a_pos : a_neg;
                  if (cw ? (pos_ext >= limit_ff[1]) : (pos_ext <= limit_ff[1]))
                     phase_in = PH_CRUISE;
               end
               PH_CRUISE: begin
                  accel_in = '0;
                  if (!cont_ff && (cw ? (pos_ext >= limit_ff[2]) : (pos_ext <= limit_ff[2])))
                     phase_in = PH_DECEL;
               end
               PH_DECEL: begin
                  if (cw ? (pos_ext >= limit_ff[3]) : (pos_ext <= limit_ff[3])) begin
                     phase_in = PH_STOP;
                     accel_in = '0;
                     speed_in = '0;
                  end else begin
                     accel_in = cw ? a_neg : a_pos;
                  end
               end
               default: begin
                  phase_in = PH_STOP;
                  accel_in = '0;
                  speed_in = '0;
               end
            endcase
         end
         CMD_START: begin
            phase_in    = (req.start_phase <= 3'(PH_DECEL)) ? phase_type'(req.start_phase)
                                                            : PH_STOP;
            speed_in    = req.start_speed;
            dir_in      = req.direction;
            cont_in     = req.continuous;
            limit_in[0] = req.limit_decel_to_accel;
            limit_in[1] = req.limit_accel_to_cruise;
            limit_in[2] = req.limit_cruise_to_decel;
            limit_in[3] = req.limit_decel_to_stop;
         end
         CMD_STOP: begin
            phase_in = PH_STOP;
            speed_in = '0;
            accel_in = '0;
            cont_in  = 1'b0;
         end
         default: begin
         end
      endcase

      result.speed_out     = speed_in;
      result.step_position = DATA_W'(pos_in);
      result.phase_out     = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STOP;
         speed_ff <= '0;
         accel_ff <= '0;
         acc_ff   <= '0;
         pos_ff   <= '0;
         dir_ff   <= 1'b0;
         cont_ff  <= 1'b0;
         for (int i = 0; i < LIMIT_N; i++) limit_ff[i] <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         speed_ff <= speed_in;
         accel_ff <= accel_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         dir_ff   <= dir_in;
         cont_ff  <= cont_in;
         for (int i = 0; i < LIMIT_N; i++) limit_ff[i] <= limit_in[i];
      end
   end

endmodule
